FILE: sv/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, constants and helpers for the pointer shift sample store.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int LEVEL_W     = 16;
    localparam int ATTEN_W     = 9;
    localparam int STAGE_NUM_W = 4;
    localparam int PLUG_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 45;
    localparam int ATTEN_PER_REG = 5;
    localparam int NUM_DET     = 7;
    localparam int PROD_W      = LEVEL_W + ATTEN_W + 1;

    localparam logic signed [LEVEL_W-1:0] TEN_VOLTS = 16'sd20480;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sd32767;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -16'sd32768;
    localparam logic [ATTEN_W-1:0]        UNITY     = 9'd256;
    localparam logic signed [LEVEL_W-1:0] LOW_THR_RST  = 16'sd205;
    localparam logic signed [LEVEL_W-1:0] HIGH_THR_RST = 16'sd2048;
    localparam logic [CFG_DATA_W-1:0]     ATTEN_RST    = 45'd17626613022976;

    // detector slots
    localparam int DET_SRC_UP    = 0;
    localparam int DET_SRC_DOWN  = 1;
    localparam int DET_SRC_RESET = 2;
    localparam int DET_DST_UP    = 3;
    localparam int DET_DST_DOWN  = 4;
    localparam int DET_DST_RESET = 5;
    localparam int DET_SAMPLE    = 6;

    // plugged_mask bits
    localparam int PLUG_EXT       = 0;
    localparam int PLUG_DST_UP    = 1;
    localparam int PLUG_DST_DOWN  = 2;
    localparam int PLUG_DST_RESET = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_LOW   = 2'd0,
        CFG_EDGE_HIGH  = 2'd1,
        CFG_ATTEN_LOW  = 2'd2,
        CFG_ATTEN_HIGH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] external_level;
        logic [PLUG_W-1:0]         plugged_mask;
        logic signed [LEVEL_W-1:0] src_up_level;
        logic signed [LEVEL_W-1:0] src_down_level;
        logic signed [LEVEL_W-1:0] src_reset_level;
        logic signed [LEVEL_W-1:0] dst_up_level;
        logic signed [LEVEL_W-1:0] dst_down_level;
        logic signed [LEVEL_W-1:0] dst_reset_level;
        logic signed [LEVEL_W-1:0] sample_level;
    } tick_item_t;

    typedef struct packed {
        logic [STAGE_NUM_W-1:0]    stage_number;
        logic signed [LEVEL_W-1:0] stage_level;
        logic                      gate_on;
        logic                      source_mark;
        logic                      last_stage;
    } result_item_t;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic write;
        logic read;
        logic mult;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sample;
        logic last;
    } dp_status_t;

    // returns {armed_next, edge}
    function automatic logic [1:0] schmitt(
        input logic                      armed,
        input logic signed [LEVEL_W-1:0] level,
        input logic signed [LEVEL_W-1:0] low_thr,
        input logic signed [LEVEL_W-1:0] high_thr
    );
        logic [1:0] r;
        if (armed)
            r = {!(level <= low_thr), 1'b0};
        else if (level >= high_thr)
            r = 2'b11;
        else
            r = 2'b00;
        return r;
    endfunction

endpackage

FILE: sv/pss_channels.sv
// ----------------------------------------------------------------------------
// pss channels
// Valid/ready channels for tick items and stage result items.
// ----------------------------------------------------------------------------
interface pss_tick_if;
    logic                valid;
    logic                ready;
    pss_pkg::tick_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pss_result_if;
    logic                  valid;
    logic                  ready;
    pss_pkg::result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/pss_ctrl.sv
// ----------------------------------------------------------------------------
// pss_ctrl
// Sequencer: takes a tick, runs the sample move, then walks the stages.
// ----------------------------------------------------------------------------
module pss_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick_valid,
    output logic                   tick_ready,
    output logic                   result_valid,
    input  logic                   result_ready,
    input  pss_pkg::dp_status_t    status,
    output pss_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WRITE,
        ST_READ,
        ST_MULT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || result_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.accept = (state_reg == ST_IDLE) && tick_valid;
        cmd.fetch  = (state_reg == ST_FETCH);
        cmd.write  = (state_reg == ST_WRITE) && status.sample;
        cmd.read   = (state_reg == ST_READ);
        cmd.mult   = (state_reg == ST_MULT);
        cmd.load   = (state_reg == ST_EMIT) && slot_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result_ready;
        case (state_reg)
            ST_IDLE:
                if (tick_valid)
                    state_next = ST_FETCH;
            ST_FETCH:
                state_next = ST_WRITE;
            ST_WRITE:
                state_next = ST_READ;
            ST_READ:
                state_next = ST_MULT;
            ST_MULT:
                state_next = ST_EMIT;
            ST_EMIT:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = status.last ? ST_IDLE : ST_READ;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign tick_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

FILE: sv/pss_datapath.sv
// ----------------------------------------------------------------------------
// pss_datapath
// Edge detectors, pointers, stage memory, attenuator multiply and result
// register.
// ----------------------------------------------------------------------------
module pss_datapath
#(
    parameter int STAGE_COUNT = 10
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pss_pkg::ctrl_cmd_t                   cmd,
    output pss_pkg::dp_status_t                  status,
    input  pss_pkg::tick_item_t                  tick_data,
    output pss_pkg::result_item_t                result_data,
    input  logic                                 wr_en,
    input  logic [pss_pkg::CFG_IDX_W-1:0]        wr_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]       wr_data
);

    localparam int PTR_W = $clog2(STAGE_COUNT);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(STAGE_COUNT - 1);
    localparam logic [PTR_W-1:0] DST_RST  = PTR_W'(7 % STAGE_COUNT);
    localparam int LW = pss_pkg::LEVEL_W;
    localparam int AW = pss_pkg::ATTEN_W;

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_PTR : p - 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    // configuration
    logic signed [LW-1:0]              low_thr_reg, high_thr_reg;
    logic [pss_pkg::CFG_DATA_W-1:0]    atten_lo_reg, atten_hi_reg;

    // control state
    logic [pss_pkg::NUM_DET-1:0] armed_reg, armed_next;
    logic [PTR_W-1:0]            src_ptr_reg, src_ptr_next;
    logic [PTR_W-1:0]            dst_ptr_reg, dst_ptr_next;
    logic                        sample_reg, sample_next;
    logic [PTR_W-1:0]            idx_reg;
    logic [STAGE_COUNT-1:0]      written_reg;

    // payload
    logic signed [LW-1:0]                  ext_sel_reg;
    logic signed [LW-1:0]                  stage_mem [STAGE_COUNT];
    logic signed [LW-1:0]                  rd_data_reg;
    logic                                  rd_valid_reg;
    logic signed [pss_pkg::PROD_W-1:0]     prod_reg;
    pss_pkg::result_item_t                 out_reg;

    logic [PTR_W-1:0]            rd_addr;
    logic signed [LW-1:0]        rd_value;
    logic signed [LW-1:0]        wr_value;
    logic [AW-1:0]               atten_arr [STAGE_COUNT];
    logic signed [pss_pkg::PROD_W-1:0] prod_next;
    logic signed [LW+1:0]        scaled;
    logic signed [LW-1:0]        level_sat;

    // tick update: detectors and pointers
    always_comb
    begin
        logic [1:0] s_up, s_dn, s_rs, d_up, d_dn, d_rs, smp;
        logic       e_up, e_dn, e_rs;
        armed_next = armed_reg;

        s_up = pss_pkg::schmitt(armed_reg[pss_pkg::DET_SRC_UP],
                                tick_data.src_up_level, low_thr_reg, high_thr_reg);
        s_dn = pss_pkg::schmitt(armed_reg[pss_pkg::DET_SRC_DOWN],
                                tick_data.src_down_level, low_thr_reg, high_thr_reg);
        s_rs = pss_pkg::schmitt(armed_reg[pss_pkg::DET_SRC_RESET],
                                tick_data.src_reset_level, low_thr_reg, high_thr_reg);
        d_up = pss_pkg::schmitt(armed_reg[pss_pkg::DET_DST_UP],
                                tick_data.dst_up_level, low_thr_reg, high_thr_reg);
        d_dn = pss_pkg::schmitt(armed_reg[pss_pkg::DET_DST_DOWN],
                                tick_data.dst_down_level, low_thr_reg, high_thr_reg);
        d_rs = pss_pkg::schmitt(armed_reg[pss_pkg::DET_DST_RESET],
                                tick_data.dst_reset_level, low_thr_reg, high_thr_reg);
        smp  = pss_pkg::schmitt(armed_reg[pss_pkg::DET_SAMPLE],
                                tick_data.sample_level, low_thr_reg, high_thr_reg);

        armed_next[pss_pkg::DET_SRC_UP]    = s_up[1];
        armed_next[pss_pkg::DET_SRC_DOWN]  = s_dn[1];
        armed_next[pss_pkg::DET_SRC_RESET] = s_rs[1];
        armed_next[pss_pkg::DET_SAMPLE]    = smp[1];

        e_up = s_up[0];
        e_dn = s_dn[0];
        e_rs = s_rs[0];

        src_ptr_next = src_ptr_reg;
        if (s_up[0])
            src_ptr_next = ptr_dec(src_ptr_next);
        if (s_dn[0])
            src_ptr_next = ptr_inc(src_ptr_next);
        if (s_rs[0])
            src_ptr_next = LAST_PTR;

        // unplugged destination controls follow the source edges
        if (tick_data.plugged_mask[pss_pkg::PLUG_DST_UP])
        begin
            armed_next[pss_pkg::DET_DST_UP] = d_up[1];
            e_up = d_up[0];
        end
        if (tick_data.plugged_mask[pss_pkg::PLUG_DST_DOWN])
        begin
            armed_next[pss_pkg::DET_DST_DOWN] = d_dn[1];
            e_dn = d_dn[0];
        end
        if (tick_data.plugged_mask[pss_pkg::PLUG_DST_RESET])
        begin
            armed_next[pss_pkg::DET_DST_RESET] = d_rs[1];
            e_rs = d_rs[0];
        end

        dst_ptr_next = dst_ptr_reg;
        if (e_up)
            dst_ptr_next = ptr_dec(dst_ptr_next);
        if (e_dn)
            dst_ptr_next = ptr_inc(dst_ptr_next);
        if (e_rs)
            dst_ptr_next = LAST_PTR;

        sample_next = smp[0];
    end

    // attenuator per stage
    always_comb
    begin
        for (int i = 0; i < STAGE_COUNT; i++)
        begin
            if (i < pss_pkg::ATTEN_PER_REG)
                atten_arr[i] = atten_lo_reg[AW*i +: AW];
            else if (i < 2 * pss_pkg::ATTEN_PER_REG)
                atten_arr[i] = atten_hi_reg[AW*(i - pss_pkg::ATTEN_PER_REG) +: AW];
            else
                atten_arr[i] = pss_pkg::UNITY;
        end
    end

    // source 0 takes the external level, so the wrapped fetch is never used
    assign rd_addr  = cmd.fetch ? ptr_dec(src_ptr_reg) : idx_reg;
    assign rd_value = rd_valid_reg ? rd_data_reg : pss_pkg::TEN_VOLTS;
    assign wr_value = (src_ptr_reg == '0) ? ext_sel_reg : rd_value;

    assign prod_next = rd_value * $signed({1'b0, atten_arr[idx_reg]});
    assign scaled    = prod_reg[pss_pkg::PROD_W-1:8];

    always_comb
    begin
        if (scaled > (LW+2)'(pss_pkg::LEVEL_MAX))
            level_sat = pss_pkg::LEVEL_MAX;
        else if (scaled < (LW+2)'(pss_pkg::LEVEL_MIN))
            level_sat = pss_pkg::LEVEL_MIN;
        else
            level_sat = scaled[LW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= pss_pkg::LOW_THR_RST;
            high_thr_reg <= pss_pkg::HIGH_THR_RST;
            atten_lo_reg <= pss_pkg::ATTEN_RST;
            atten_hi_reg <= pss_pkg::ATTEN_RST;
            armed_reg    <= '1;
            src_ptr_reg  <= LAST_PTR;
            dst_ptr_reg  <= DST_RST;
            sample_reg   <= 1'b0;
            idx_reg      <= '0;
            written_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (pss_pkg::cfg_index_t'(wr_index))
                    pss_pkg::CFG_EDGE_LOW:   low_thr_reg  <= wr_data[LW-1:0];
                    pss_pkg::CFG_EDGE_HIGH:  high_thr_reg <= wr_data[LW-1:0];
                    pss_pkg::CFG_ATTEN_LOW:  atten_lo_reg <= wr_data;
                    pss_pkg::CFG_ATTEN_HIGH: atten_hi_reg <= wr_data;
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                armed_reg   <= armed_next;
                src_ptr_reg <= src_ptr_next;
                dst_ptr_reg <= dst_ptr_next;
                sample_reg  <= sample_next;
                idx_reg     <= '0;
            end
            if (cmd.write)
                written_reg[dst_ptr_reg] <= 1'b1;
            if (cmd.fetch || cmd.read)
                rd_valid_reg <= written_reg[rd_addr];
            if (cmd.load)
                idx_reg <= (idx_reg == LAST_PTR) ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            ext_sel_reg <= tick_data.plugged_mask[pss_pkg::PLUG_EXT] ?
                           tick_data.external_level : pss_pkg::TEN_VOLTS;
        if (cmd.write)
            stage_mem[dst_ptr_reg] <= wr_value;
        if (cmd.fetch || cmd.read)
            rd_data_reg <= stage_mem[rd_addr];
        if (cmd.mult)
            prod_reg <= prod_next;
        if (cmd.load)
        begin
            out_reg.stage_number <= pss_pkg::STAGE_NUM_W'(idx_reg);
            out_reg.stage_level  <= level_sat;
            out_reg.gate_on      <= (idx_reg == dst_ptr_reg);
            out_reg.source_mark  <= (idx_reg == src_ptr_reg);
            out_reg.last_stage   <= (idx_reg == LAST_PTR);
        end
    end

    assign status.sample = sample_reg;
    assign status.last   = (idx_reg == LAST_PTR);
    assign result_data   = out_reg;

endmodule

FILE: sv/pointer_shift_sample_store.sv
// ----------------------------------------------------------------------------
// pointer_shift_sample_store
// Pointer-addressed shift-register sample store: edge-driven source and
// destination pointers, sample move, one attenuated result per stage.
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// tick      in   valid/ready    pss_pkg::tick_item_t
// result    out  valid/ready    pss_pkg::result_item_t, STAGE_COUNT per tick
// wr_*      in   wr_en only     register index and 45-bit data
//
// A tick is accepted, then the sample move fetches and writes through the
// stage memory's single port, then each stage is read, multiplied and
// emitted in turn. tick.ready is high only between ticks. A stalled
// result holds the walk at the emit step.
// Reset restores thresholds, attenuators, pointers and detectors at once;
// unwritten stages read as 10 V through per-stage written flags.
// ----------------------------------------------------------------------------
module pointer_shift_sample_store
#(
    parameter int STAGE_COUNT = 10
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    pss_tick_if.sink                          tick,
    pss_result_if.source                      result,
    input  logic                              wr_en,
    input  logic [pss_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]    wr_data
);

    pss_pkg::ctrl_cmd_t  cmd;
    pss_pkg::dp_status_t status;

    pss_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick.valid),
        .tick_ready   (tick.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    pss_datapath #(.STAGE_COUNT(STAGE_COUNT)) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .tick_data   (tick.data),
        .result_data (result.data),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

endmodule

FILE: sv/pss_checker.sv
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks for the pointer shift sample store.
// ----------------------------------------------------------------------------
module pss_checker
#(
    parameter int STAGE_COUNT = 10
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   tick_valid,
    input logic                   tick_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input pss_pkg::result_item_t  result_data
);

    localparam logic [pss_pkg::STAGE_NUM_W-1:0] LAST_NUM =
        pss_pkg::STAGE_NUM_W'(STAGE_COUNT - 1);

    a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick taken while previous tick still in progress");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.last_stage == (result_data.stage_number == LAST_NUM)))
        else $error("last_stage does not match final stage number");

    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.stage_number <= LAST_NUM)
        else $error("stage number out of range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

endmodule

bind pointer_shift_sample_store pss_checker #(.STAGE_COUNT(STAGE_COUNT)) u_pss_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick.valid),
    .tick_ready   (tick.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
